// File: design/integer_to_ascii_radix_macros.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_radix assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

// Same-cycle implication
`define I2A_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define I2A_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Codes, character constants and digit helpers for integer_to_ascii_radix.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Base select codes
  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;
  localparam logic [1:0] BASE_BAD = 2'd3;

  // ASCII characters
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_QMARK = 8'h3f;
  localparam logic [7:0] CHAR_B     = 8'h62;
  localparam logic [7:0] CHAR_X     = 8'h78;

  // Digit places and BCD buffer
  localparam int DIGIT_SLOTS       = 32;
  localparam int MAX_PAD_WIDTH_DEF = 32;
  localparam int BCD_DIGITS        = 10;
  localparam int BCD_W             = 4 * BCD_DIGITS;
  localparam int HEX_PLACES        = 8;

  typedef logic [BCD_W-1:0] digit_reg_t;

  // Lowercase hex character of one digit
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = 8'h57 + {4'd0, d};
    end
    return c;
  endfunction

  // Double-dabble correction: add 3 to every BCD nibble of 5 or more
  function automatic digit_reg_t dabble_adjust(input digit_reg_t b);
    digit_reg_t r;
    r = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  // True when every nibble is a decimal digit
  function automatic logic bcd_valid(input digit_reg_t b);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (b[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// File: design/integer_to_ascii_radix.sv
// Sequence: binary/hex send the 0b/0x prefix if asked, then run the digit scan;
// decimal runs the double-dabble loop, then a minus sign if negative, then the scan.
// A new number is taken only in idle, once the last character of the previous
// one has been registered; the pace is set by the 32-place digit scan and the
// 1-bit-per-cycle double-dabble loop, and is longer when the sink stalls.
// Reset: synchronous active-low rst_n returns to idle with no pending output.
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Formats a 32-bit number as ASCII in binary, decimal or hexadecimal with
// optional prefix, minus sign and zero padding, one character per transfer.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_radix_macros.svh"

module integer_to_ascii_radix #(
  parameter int MAX_PAD_WIDTH = i2a_pkg::MAX_PAD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_base_select,
  input  logic        in_is_signed,
  input  logic        in_with_prefix,
  input  logic [5:0]  in_pad_width,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CONV   = 3'd1;
  localparam logic [2:0] ST_PRE0   = 3'd2;
  localparam logic [2:0] ST_PRE1   = 3'd3;
  localparam logic [2:0] ST_SIGN   = 3'd4;
  localparam logic [2:0] ST_DIGITS = 3'd5;
  localparam logic [2:0] ST_QMARK  = 3'd6;

  localparam logic [4:0] K_TOP   = 5'(i2a_pkg::DIGIT_SLOTS - 1);
  localparam logic [5:0] PAD_MAX = 6'(MAX_PAD_WIDTH);
  localparam logic [5:0] PAD_BUF = 6'(i2a_pkg::DIGIT_SLOTS);
  localparam int         DW      = i2a_pkg::BCD_W;

  logic [2:0]          state_r, state_nxt;
  logic [1:0]          sel_r, sel_nxt;
  logic                neg_r, neg_nxt;
  logic                pfx_r, pfx_nxt;
  logic [5:0]          pad_r, pad_nxt;
  logic [4:0]          k_r, k_nxt;
  logic                started_r, started_nxt;
  logic [31:0]         bin_r, bin_nxt;
  i2a_pkg::digit_reg_t dreg_r, dreg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic                in_xfer;
  logic                out_free;
  logic                neg_in;
  logic [31:0]         mag_in;
  logic [5:0]          pad_sat;
  i2a_pkg::digit_reg_t adj;
  logic                in_range;
  logic [3:0]          digit;
  logic                emit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  // Input decode: sign, magnitude, saturated pad width
  always_comb begin
    neg_in  = (in_base_select == i2a_pkg::BASE_DEC) && in_is_signed && in_value[31];
    mag_in  = neg_in ? (32'd0 - in_value) : in_value;
    pad_sat = in_pad_width;
    if (pad_sat > PAD_MAX) begin
      pad_sat = PAD_MAX;
    end
    if (pad_sat > PAD_BUF) begin
      pad_sat = PAD_BUF;
    end
  end

  // Current digit place
  always_comb begin
    adj = i2a_pkg::dabble_adjust(dreg_r);
    unique case (sel_r)
      i2a_pkg::BASE_BIN: in_range = 1'b1;
      i2a_pkg::BASE_HEX: in_range = (k_r < 5'(i2a_pkg::HEX_PLACES));
      default:           in_range = (k_r < 5'(i2a_pkg::BCD_DIGITS));
    endcase
    if (!in_range) begin
      digit = 4'd0;
    end else if (sel_r == i2a_pkg::BASE_BIN) begin
      digit = {3'd0, dreg_r[DW-1]};
    end else begin
      digit = dreg_r[DW-1 -: 4];
    end
    emit = started_r || (digit != 4'd0) || (k_r == 5'd0) || ({1'b0, k_r} < pad_r);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    neg_nxt       = neg_r;
    pfx_nxt       = pfx_r;
    pad_nxt       = pad_r;
    k_nxt         = k_r;
    started_nxt   = started_r;
    bin_nxt       = bin_r;
    dreg_nxt      = dreg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          sel_nxt     = in_base_select;
          neg_nxt     = neg_in;
          pfx_nxt     = in_with_prefix;
          pad_nxt     = (neg_in && pad_sat != 6'd0) ? pad_sat - 6'd1 : pad_sat;
          bin_nxt     = mag_in;
          k_nxt       = K_TOP;
          started_nxt = 1'b0;
          if (in_base_select == i2a_pkg::BASE_DEC) begin
            dreg_nxt = '0;
          end else begin
            dreg_nxt = {in_value, 8'd0};
          end
          priority if (in_base_select == i2a_pkg::BASE_BAD) begin
            state_nxt = ST_QMARK;
          end else if (in_base_select == i2a_pkg::BASE_DEC) begin
            state_nxt = ST_CONV;
          end else if (in_with_prefix) begin
            state_nxt = ST_PRE0;
          end else begin
            state_nxt = ST_DIGITS;
          end
        end
      end
      ST_CONV: begin
        // one bit of double dabble per cycle
        dreg_nxt = {adj[DW-2:0], bin_r[31]};
        bin_nxt  = {bin_r[30:0], 1'b0};
        k_nxt    = k_r - 5'd1;
        if (k_r == 5'd0) begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGITS;
        end
      end
      ST_PRE0: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = i2a_pkg::CHAR_ZERO;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_PRE1;
        end
      end
      ST_PRE1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = (sel_r == i2a_pkg::BASE_BIN) ? i2a_pkg::CHAR_B : i2a_pkg::CHAR_X;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = i2a_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        // scan 32 places, most significant first; skipped places send nothing
        if (!emit || out_free) begin
          if (in_range) begin
            if (sel_r == i2a_pkg::BASE_BIN) begin
              dreg_nxt = {dreg_r[DW-2:0], 1'b0};
            end else begin
              dreg_nxt = {dreg_r[DW-5:0], 4'd0};
            end
          end
          k_nxt = k_r - 5'd1;
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = i2a_pkg::hex_char(digit);
            out_last_nxt  = (k_r == 5'd0);
            started_nxt   = 1'b1;
          end
          if (k_r == 5'd0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_QMARK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = i2a_pkg::CHAR_QMARK;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    neg_r      <= neg_nxt;
    pfx_r      <= pfx_nxt;
    pad_r      <= pad_nxt;
    k_r        <= k_nxt;
    started_r  <= started_nxt;
    bin_r      <= bin_nxt;
    dreg_r     <= dreg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Checks
  `I2A_ASSERT_NXT(a_last_on_final_place,
    state_r == ST_DIGITS && k_r == 5'd0 && out_free,
    out_valid && out_last,
    "final digit place did not produce a last character")
  `I2A_ASSERT_IMP(a_bcd_digits_valid,
    state_r == ST_DIGITS && sel_r == i2a_pkg::BASE_DEC,
    i2a_pkg::bcd_valid(dreg_r),
    "decimal digit buffer holds a non-decimal nibble")
  `I2A_ASSERT_IMP(a_pad_in_range,
    state_r != ST_IDLE,
    pad_r <= PAD_BUF,
    "pad width exceeds digit buffer")
  `I2A_ASSERT_IMP(a_prefix_only_bin_hex,
    state_r == ST_PRE0 || state_r == ST_PRE1,
    pfx_r && (sel_r == i2a_pkg::BASE_BIN || sel_r == i2a_pkg::BASE_HEX),
    "prefix sent for a base without one")

endmodule

// File: tb/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker
// Watches both channels of integer_to_ascii_radix. Every accepted number is
// formatted into the characters it should produce. Every character transfer
// is compared in order against those characters, together with its last flag.
// ----------------------------------------------------------------------------
module i2a_checker
  import i2a_pkg::*;
#(
  parameter int MAX_PAD_WIDTH = MAX_PAD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_value,
  input  logic [1:0]  in_base_select,
  input  logic        in_is_signed,
  input  logic        in_with_prefix,
  input  logic [5:0]  in_pad_width,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_char,
  input  logic        out_last,
  output int          pending,
  output int          errors,
  output int          chars_checked
);

  localparam logic [7:0] CHAR_A_LOWER = 8'h61;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  // characters still owed by the block, oldest first
  char_beat_t expected_chars[$];
  char_beat_t exp_beat;

  // Append the characters of one formatted number to expected_chars
  function automatic void format_number(input logic [31:0] value,
                                        input logic [1:0]  base,
                                        input logic        sgn,
                                        input logic        pfx,
                                        input logic [5:0]  pad_in);
    logic [31:0] mag;
    logic [31:0] radix;
    logic [3:0]  d;
    logic [7:0]  digits[DIGIT_SLOTS];
    logic [7:0]  text[$];
    int          ndig;
    int          pad;
    mag  = value;
    ndig = 0;
    pad  = int'(pad_in);
    if (pad > MAX_PAD_WIDTH) pad = MAX_PAD_WIDTH;
    if (pad > DIGIT_SLOTS) pad = DIGIT_SLOTS;

    if (base == BASE_BAD) begin
      // invalid base: lone question mark, nothing else
      text.push_back(CHAR_QMARK);
    end else begin
      case (base)
        BASE_BIN: radix = 32'd2;
        BASE_DEC: radix = 32'd10;
        default:  radix = 32'd16;
      endcase
      // prefix only for binary and hex; it takes no pad place
      if (pfx && base != BASE_DEC) begin
        text.push_back(CHAR_ZERO);
        text.push_back((base == BASE_BIN) ? CHAR_B : CHAR_X);
      end
      // minus sign for negative signed decimal; it eats one pad place
      if (base == BASE_DEC && sgn && mag[31]) begin
        text.push_back(CHAR_MINUS);
        mag = 32'd0 - mag;
        if (pad > 0) pad--;
      end
      // digits, least significant first
      do begin
        d = 4'(mag % radix);
        digits[ndig] = (d < 4'd10) ? CHAR_ZERO + {4'd0, d}
                                   : CHAR_A_LOWER + {4'd0, d - 4'd10};
        ndig++;
        mag = mag / radix;
      end while (mag != 32'd0 && ndig < DIGIT_SLOTS);
      // leading zeros
      while (pad > ndig) begin
        text.push_back(CHAR_ZERO);
        pad--;
      end
      while (ndig > 0) begin
        ndig--;
        text.push_back(digits[ndig]);
      end
    end

    foreach (text[i]) begin
      expected_chars.push_back(char_beat_t'{ch: text[i], last: (i == text.size() - 1)});
    end
  endfunction

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        format_number(in_value, in_base_select, in_is_signed, in_with_prefix, in_pad_width);
      end
      if (out_valid && !out_stall) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: unexpected char: expected none, actual char %h last %b",
                   $time, out_char, out_last);
        end else begin
          exp_beat = expected_chars.pop_front();
          if (exp_beat.ch !== out_char || exp_beat.last !== out_last) begin
            errors++;
            $display("%0t: mismatch: expected char %h last %b, actual char %h last %b",
                     $time, exp_beat.ch, exp_beat.last, out_char, out_last);
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for integer_to_ascii_radix: a directed set of edge numbers, then
// random numbers in every base with random sign, prefix and pad width, under
// random input gaps and sink stalls. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb_top;
  import i2a_pkg::*;

  localparam int RANDOM_NUMBERS = 360;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [31:0] in_value       = '0;
  logic [1:0]  in_base_select = BASE_BIN;
  logic        in_is_signed   = 1'b0;
  logic        in_with_prefix = 1'b0;
  logic [5:0]  in_pad_width   = '0;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_char;
  logic        out_last;

  int pending;
  int errors;
  int chars_checked;
  int numbers_sent;
  int base_count[4];
  bit idle_on = 1'b1;

  integer_to_ascii_radix #(
    .MAX_PAD_WIDTH(MAX_PAD_WIDTH_DEF)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_base_select(in_base_select),
    .in_is_signed  (in_is_signed),
    .in_with_prefix(in_with_prefix),
    .in_pad_width  (in_pad_width),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last      (out_last)
  );

  i2a_checker #(
    .MAX_PAD_WIDTH(MAX_PAD_WIDTH_DEF)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_base_select(in_base_select),
    .in_is_signed  (in_is_signed),
    .in_with_prefix(in_with_prefix),
    .in_pad_width  (in_pad_width),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last      (out_last),
    .pending       (pending),
    .errors        (errors),
    .chars_checked (chars_checked)
  );

  // Clock
  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(20 * 800000);
    $display("DONE: errors detected");
    $finish;
  end

  // Sink stalls
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 16);
  end

  // Offer one number and hold it until the transfer
  task automatic send_number(input logic [31:0] value, input logic [1:0] base,
                             input logic sgn, input logic pfx, input logic [5:0] pad);
    while (idle_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_base_select <= base;
    in_is_signed   <= sgn;
    in_with_prefix <= pfx;
    in_pad_width   <= pad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    numbers_sent++;
    base_count[base]++;
  endtask

  // Let every owed character arrive; pending is checked only after a falling clock edge
  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
  endtask

  // Mix of full-range, short and boundary values
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(5))
      0:       v = $urandom_range(255);
      1:       v = $urandom >> $urandom_range(31);
      2:       v = 32'h8000_0000 + $urandom_range(3) - 32'd2;
      3:       v = 32'hffff_ffff - $urandom_range(255);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Main sequence
  initial begin
    logic [1:0] base;
    logic [5:0] pad;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed edge numbers
    send_number(32'd0,          BASE_BIN, 1'b0, 1'b0, 6'd0);
    send_number(32'd0,          BASE_DEC, 1'b0, 1'b0, 6'd0);
    send_number(32'd0,          BASE_HEX, 1'b0, 1'b0, 6'd1);
    send_number(32'hffff_ffff,  BASE_BIN, 1'b0, 1'b1, 6'd0);
    send_number(32'hffff_ffff,  BASE_HEX, 1'b0, 1'b1, 6'd0);
    send_number(32'hffff_ffff,  BASE_DEC, 1'b0, 1'b0, 6'd0);
    send_number(32'hffff_ffff,  BASE_DEC, 1'b1, 1'b0, 6'd0);
    send_number(32'h8000_0000,  BASE_DEC, 1'b1, 1'b0, 6'd0);
    send_number(32'h8000_0000,  BASE_DEC, 1'b0, 1'b0, 6'd0);
    send_number(32'h7fff_ffff,  BASE_DEC, 1'b1, 1'b0, 6'd12);
    send_number(32'h1234_5678,  BASE_BAD, 1'b1, 1'b1, 6'd63);
    send_number(32'd0,          BASE_BAD, 1'b0, 1'b0, 6'd0);
    send_number(32'h8000_0000,  BASE_BIN, 1'b1, 1'b0, 6'd0);
    send_number(32'hfedc_ba98,  BASE_HEX, 1'b1, 1'b0, 6'd0);
    send_number(32'd12345,      BASE_DEC, 1'b0, 1'b1, 6'd8);
    send_number(32'h0000_00ab,  BASE_HEX, 1'b0, 1'b1, 6'd63);
    send_number(32'd0,          BASE_BIN, 1'b0, 1'b1, 6'd32);
    send_number(32'd77,         BASE_DEC, 1'b0, 1'b0, 6'd33);
    send_number(-32'sd42,       BASE_DEC, 1'b1, 1'b0, 6'd5);
    send_number(-32'sd7,        BASE_DEC, 1'b1, 1'b0, 6'd1);
    send_number(-32'sd3,        BASE_DEC, 1'b1, 1'b1, 6'd40);
    send_number(32'hdead_beef,  BASE_HEX, 1'b0, 1'b1, 6'd10);
    send_number(32'h0000_0005,  BASE_BIN, 1'b0, 1'b0, 6'd8);

    // hold off until the block is fully drained
    in_valid <= 1'b0;
    wait_drained();

    // random numbers; a quiet stretch with no gaps or stalls in the middle
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      idle_on = !(n >= 140 && n < 220);
      if (n == 250) begin
        in_valid <= 1'b0;
        wait_drained();
      end
      base = ($urandom_range(9) == 0) ? BASE_BAD : 2'($urandom_range(2));
      pad  = ($urandom_range(7) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12));
      send_number(pick_value(), base, 1'($urandom_range(1)), 1'($urandom_range(1)), pad);
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (80) @(negedge clk);

    $display("Covered %0d numbers: %0d binary, %0d decimal, %0d hex, %0d invalid base",
             numbers_sent, base_count[BASE_BIN], base_count[BASE_DEC],
             base_count[BASE_HEX], base_count[BASE_BAD]);
    $display("%0d characters compared across sign, prefix, padding and sink stalls",
             chars_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
